FILE: hw/rtl/lplg_pkg.sv
// Package for the LED pattern level generator: item kinds, side-band structs,
// configuration layout, pattern timing constants and datapath widths.
// No dependencies.
package lplg_pkg;

   localparam int NOW_W      = 32;
   localparam int PERIOD_W   = 16;
   localparam int HOUR_W     = 5;
   localparam int LEVEL_W    = 8;
   localparam int NUM_W      = 23;
   localparam int SCALED_W   = 31;
   localparam int SCALE_W    = 23;
   localparam int QUOT_W     = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [3:0] MODE_AUTO      = 4'd0;
   localparam logic [3:0] MODE_ON        = 4'd1;
   localparam logic [3:0] MODE_OFF       = 4'd2;
   localparam logic [3:0] MODE_BREATHE   = 4'd3;
   localparam logic [3:0] MODE_SLOW      = 4'd4;
   localparam logic [3:0] MODE_FAST      = 4'd5;
   localparam logic [3:0] MODE_DOUBLE    = 4'd6;
   localparam logic [3:0] MODE_HEARTBEAT = 4'd7;
   localparam logic [3:0] MODE_PULSE     = 4'd8;
   localparam logic [3:0] MODE_CANDLE    = 4'd9;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BREATH_PERIOD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_START = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_END = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POLARITY = 3'd4;

   localparam logic [PERIOD_W-1:0] PULSE_PERIOD_MS = 16'd1800;
   localparam logic [PERIOD_W-1:0] SLOW_BLINK_MS   = 16'd700;
   localparam logic [PERIOD_W-1:0] FAST_BLINK_MS   = 16'd180;
   localparam logic [PERIOD_W-1:0] DOUBLE_CYCLE_MS = 16'd1400;
   localparam logic [PERIOD_W-1:0] HEART_CYCLE_MS  = 16'd1500;
   localparam logic [PERIOD_W-1:0] CANDLE_CYCLE_MS = 16'd997;
   localparam logic [PERIOD_W-1:0] MIN_PERIOD_MS   = 16'd2;
   localparam logic [SCALE_W-1:0]  CANDLE_SPAN     = 23'd70;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 8'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_DARK  = 8'd0;
   localparam logic [LEVEL_W-1:0] CANDLE_BASE = 8'd150;
   localparam logic [LEVEL_W-1:0] CANDLE_DIP  = 8'd60;

   typedef enum logic [2:0] {
      KIND_FIXED,
      KIND_BLINK,
      KIND_DOUBLE,
      KIND_HEART,
      KIND_RAMP,
      KIND_PULSE,
      KIND_CANDLE
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [LEVEL_W-1:0]   level;
   } tag_type;

   typedef struct packed {
      kind_type             kind;
      logic [LEVEL_W-1:0]   level;
      logic                 dip;
   } mark_type;

   typedef struct packed {
      logic [3:0]           mode;
      logic [PERIOD_W-1:0]  period;
      logic [HOUR_W-1:0]    start_hour;
      logic [HOUR_W-1:0]    end_hour;
      logic                 polarity;
   } cfg_type;

endpackage

FILE: hw/rtl/lplg_divider.sv
// Pipelined restoring divider, one quotient bit per register stage, carrying a
// side-band payload alongside each word. Depends on nothing.
module lplg_divider #(
   parameter int N      = 32,
   parameter int M      = 16,
   parameter int Q      = 32,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [N-1:0]      in_dividend,
   input  logic [M-1:0]      in_divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q-1:0]      out_quotient,
   output logic [M-1:0]      out_remainder,
   output logic [M-1:0]      out_divisor,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [Q];
   logic [M-1:0]      rem_ff   [Q];
   logic [Q-1:0]      bits_ff  [Q];
   logic [M-1:0]      div_ff   [Q];
   logic [SIDE_W-1:0] side_ff  [Q];
   logic [N+M-1:0]    dividend_ext;

   assign dividend_ext = {{M{1'b0}}, in_dividend};

   for (genvar s = 0; s < Q; s++) begin : g_step
      logic              valid_src;
      logic [M-1:0]      rem_src;
      logic [Q-1:0]      bits_src;
      logic [M-1:0]      div_src;
      logic [SIDE_W-1:0] side_src;
      logic [M:0]        trial;
      logic [M:0]        diff;
      logic              take;
      logic [M-1:0]      rem_in;
      logic [Q-1:0]      bits_in;

      if (s == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = M'(dividend_ext >> Q);
         assign bits_src  = in_dividend[Q-1:0];
         assign div_src   = in_divisor;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[s-1];
         assign rem_src   = rem_ff[s-1];
         assign bits_src  = bits_ff[s-1];
         assign div_src   = div_ff[s-1];
         assign side_src  = side_ff[s-1];
      end

      assign trial   = {rem_src, bits_src[Q-1]};
      assign diff    = trial - {1'b0, div_src};
      assign take    = (trial >= {1'b0, div_src});
      assign rem_in  = take ? diff[M-1:0] : trial[M-1:0];
      assign bits_in = Q'({bits_src, take});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            bits_ff[s] <= bits_in;
            div_ff[s]  <= div_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid     = valid_ff[Q-1];
   assign out_quotient  = bits_ff[Q-1];
   assign out_remainder = rem_ff[Q-1];
   assign out_divisor   = div_ff[Q-1];
   assign out_side      = side_ff[Q-1];

endmodule

FILE: hw/rtl/lplg_decode.sv
// Input stage: picks the pattern kind and the divisor for each word from the
// link, touch, hour window and configuration. Depends on lplg_pkg.
module lplg_decode import lplg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  cfg_type             cfg,
   input  logic                in_valid,
   input  logic [NOW_W-1:0]    now_ms,
   input  logic [HOUR_W-1:0]   hour_of_day,
   input  logic                hour_valid,
   input  logic                touch,
   input  logic                link_up,
   output logic                out_valid,
   output logic [NOW_W-1:0]    out_now,
   output logic [PERIOD_W-1:0] out_divisor,
   output tag_type             out_tag
);

   logic                valid_ff;
   logic [NOW_W-1:0]    now_ff;
   logic [PERIOD_W-1:0] divisor_ff;
   logic [PERIOD_W-1:0] divisor_in;
   tag_type             tag_ff;
   tag_type             tag_in;
   logic [PERIOD_W-1:0] period;
   logic                window_open;

   assign period = (cfg.period < MIN_PERIOD_MS) ? MIN_PERIOD_MS : cfg.period;

   always_comb begin
      if (cfg.start_hour > cfg.end_hour) begin
         window_open = (hour_of_day >= cfg.start_hour) || (hour_of_day < cfg.end_hour);
      end else begin
         window_open = (hour_of_day >= cfg.start_hour) && (hour_of_day < cfg.end_hour);
      end
   end

   always_comb begin
      tag_in.kind  = KIND_FIXED;
      tag_in.level = LEVEL_DARK;
      divisor_in   = period;
      if (!link_up) begin
         tag_in.kind = KIND_BLINK;
         divisor_in  = FAST_BLINK_MS;
      end else if (touch) begin
         tag_in.level = LEVEL_FULL;
      end else begin
         case (cfg.mode)
            MODE_AUTO: begin
               if (hour_valid && window_open) begin
                  tag_in.kind = KIND_RAMP;
               end
            end
            MODE_ON: begin
               tag_in.level = LEVEL_FULL;
            end
            MODE_OFF: begin
               tag_in.level = LEVEL_DARK;
            end
            MODE_BREATHE: begin
               tag_in.kind = KIND_RAMP;
            end
            MODE_SLOW: begin
               tag_in.kind = KIND_BLINK;
               divisor_in  = SLOW_BLINK_MS;
            end
            MODE_FAST: begin
               tag_in.kind = KIND_BLINK;
               divisor_in  = FAST_BLINK_MS;
            end
            MODE_DOUBLE: begin
               tag_in.kind = KIND_DOUBLE;
               divisor_in  = DOUBLE_CYCLE_MS;
            end
            MODE_HEARTBEAT: begin
               tag_in.kind = KIND_HEART;
               divisor_in  = HEART_CYCLE_MS;
            end
            MODE_PULSE: begin
               tag_in.kind = KIND_PULSE;
               divisor_in  = PULSE_PERIOD_MS;
            end
            MODE_CANDLE: begin
               tag_in.kind = KIND_CANDLE;
               divisor_in  = CANDLE_CYCLE_MS;
            end
            default: begin
               tag_in.level = LEVEL_DARK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         now_ff     <= now_ms;
         divisor_ff <= divisor_in;
         tag_ff     <= tag_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_now     = now_ff;
   assign out_divisor = divisor_ff;
   assign out_tag     = tag_ff;

endmodule

FILE: hw/rtl/lplg_shape.sv
// Two stages between the dividers: folds the phase into the triangle distance
// or the candle terms, and scales the ramp numerator. Depends on lplg_pkg.
module lplg_shape import lplg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic                in_odd,
   input  logic [PERIOD_W-1:0] in_phase,
   input  logic [PERIOD_W-1:0] in_period,
   input  tag_type             in_tag,
   output logic                out_valid,
   output logic [SCALED_W-1:0] out_dividend,
   output logic [SCALE_W-1:0]  out_divisor,
   output mark_type            out_mark
);

   logic                valid1_ff;
   logic [NUM_W-1:0]    num1_ff;
   logic [NUM_W-1:0]    num1_in;
   logic [PERIOD_W-1:0] period1_ff;
   mark_type            mark1_ff;
   mark_type            mark1_in;

   logic                valid2_ff;
   logic [SCALED_W-1:0] dividend2_ff;
   logic [SCALED_W-1:0] dividend2_in;
   logic [SCALE_W-1:0]  divisor2_ff;
   logic [SCALE_W-1:0]  divisor2_in;
   mark_type            mark2_ff;

   logic [PERIOD_W-1:0] fold;
   logic [NUM_W-1:0]    p_ext;
   logic [NUM_W-1:0]    t_ext;
   logic [NUM_W-1:0]    ph_ext;
   logic [SCALED_W-1:0] num_ext;
   logic [SCALE_W-1:0]  p_scale;

   assign fold   = ({in_phase, 1'b0} <= {1'b0, in_period}) ? in_phase : in_period - in_phase;
   assign p_ext  = NUM_W'(in_period);
   assign t_ext  = NUM_W'(fold);
   assign ph_ext = NUM_W'(in_phase);

   always_comb begin
      mark1_in.kind  = in_tag.kind;
      mark1_in.level = in_tag.level;
      mark1_in.dip   = 1'b0;
      num1_in        = '0;
      case (in_tag.kind)
         KIND_BLINK: begin
            mark1_in.level = in_odd ? LEVEL_FULL : LEVEL_DARK;
         end
         KIND_DOUBLE: begin
            mark1_in.level = ((in_phase < 16'd120) || ((in_phase >= 16'd240) &&
                             (in_phase < 16'd360))) ? LEVEL_FULL : LEVEL_DARK;
         end
         KIND_HEART: begin
            mark1_in.level = ((in_phase < 16'd90) || ((in_phase >= 16'd140) &&
                             (in_phase < 16'd230))) ? LEVEL_FULL : LEVEL_DARK;
         end
         KIND_RAMP: begin
            num1_in = (p_ext << 3) + (p_ext << 2) + (t_ext << 7) + (t_ext << 5) + (t_ext << 4);
         end
         KIND_PULSE: begin
            num1_in = (p_ext << 2) + (t_ext << 7) + (t_ext << 6);
         end
         KIND_CANDLE: begin
            // Since 73 leaves 3 modulo 70, the wobble term only needs three times the phase.
            num1_in      = (ph_ext << 1) + ph_ext;
            mark1_in.dip = (in_phase < 16'd20) ||
                           ((in_phase >= 16'd173) && (in_phase < 16'd193)) ||
                           ((in_phase >= 16'd346) && (in_phase < 16'd366)) ||
                           ((in_phase >= 16'd519) && (in_phase < 16'd539)) ||
                           ((in_phase >= 16'd692) && (in_phase < 16'd712)) ||
                           ((in_phase >= 16'd865) && (in_phase < 16'd885));
         end
         default: begin
            num1_in = '0;
         end
      endcase
   end

   assign num_ext = SCALED_W'(num1_ff);
   assign p_scale = SCALE_W'(period1_ff);

   always_comb begin
      dividend2_in = '0;
      divisor2_in  = SCALE_W'(1);
      case (mark1_ff.kind)
         KIND_RAMP, KIND_PULSE: begin
            dividend2_in = (num_ext << 8) - num_ext;
            divisor2_in  = (p_scale << 6) + (p_scale << 5) + (p_scale << 2);
         end
         KIND_CANDLE: begin
            dividend2_in = num_ext;
            divisor2_in  = CANDLE_SPAN;
         end
         default: begin
            dividend2_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num1_ff      <= num1_in;
         period1_ff   <= in_period;
         mark1_ff     <= mark1_in;
         dividend2_ff <= dividend2_in;
         divisor2_ff  <= divisor2_in;
         mark2_ff     <= mark1_ff;
      end
   end

   assign out_valid    = valid2_ff;
   assign out_dividend = dividend2_ff;
   assign out_divisor  = divisor2_ff;
   assign out_mark     = mark2_ff;

endmodule

FILE: hw/rtl/lplg_output.sv
// Final level selection, output polarity, and the output register with a skid
// word that frees the pipeline from the result side. Depends on lplg_pkg.
module lplg_output import lplg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 polarity,
   input  logic                 in_valid,
   input  logic [QUOT_W-1:0]    in_quotient,
   input  logic [SCALE_W-1:0]   in_remainder,
   input  mark_type             in_mark,
   output logic                 advance,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [2*LEVEL_W-1:0] rsp_tdata
);

   logic                 out_valid_ff;
   logic [2*LEVEL_W-1:0] out_word_ff;
   logic                 skid_valid_ff;
   logic [2*LEVEL_W-1:0] skid_word_ff;
   logic [LEVEL_W-1:0]   level;
   logic [LEVEL_W-1:0]   duty;
   logic [2*LEVEL_W-1:0] word_in;
   logic                 slot_free;
   logic                 pipe_take;

   always_comb begin
      case (in_mark.kind)
         KIND_RAMP, KIND_PULSE: begin
            level = (in_quotient > QUOT_W'(LEVEL_FULL)) ? LEVEL_FULL : in_quotient[LEVEL_W-1:0];
         end
         KIND_CANDLE: begin
            level = CANDLE_BASE + LEVEL_W'(in_remainder) - (in_mark.dip ? CANDLE_DIP : LEVEL_DARK);
         end
         default: begin
            level = in_mark.level;
         end
      endcase
   end

   assign duty      = polarity ? level : ~level;
   assign word_in   = {duty, level};
   assign advance   = !skid_valid_ff;
   assign slot_free = !out_valid_ff || rsp_tready;
   assign pipe_take = in_valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (slot_free) begin
         out_valid_ff  <= skid_valid_ff || pipe_take;
         skid_valid_ff <= 1'b0;
      end else if (pipe_take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free) begin
         out_word_ff <= skid_valid_ff ? skid_word_ff : word_in;
      end else if (pipe_take) begin
         skid_word_ff <= word_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_word_ff;

`ifndef SYNTH
   a_skid_fills_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready))
      else $error("Skid word filled while the output register was free.");

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid word held with an empty output register.");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_tready) |=> (!skid_valid_ff && out_valid_ff))
      else $error("Skid word not moved forward after the output was taken.");
`endif

endmodule

FILE: hw/rtl/led_pattern_level_generator_core.sv
// LED pattern level generator: one brightness and PWM duty word per request word.
// From acceptance to rsp_tvalid a word passes one decode stage, 32 stages of the
// phase divider, two shaping stages, 9 stages of the ramp divider and the output register.
// One word per cycle while the skid word is free; a stalled result side fills the one-word skid.
// Synchronous active-high reset empties the pipeline and loads the register defaults.
// Depends on lplg_pkg, lplg_decode, lplg_divider, lplg_shape and lplg_output.
module led_pattern_level_generator_core import lplg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now_ms [31:0], hour_of_day [36:32], hour_valid [37], touch [38],
   // link_up [39].
   input  logic [39:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // brightness [7:0], pwm_duty [15:8].
   output logic [15:0]           rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type             cfg_ff;
   logic                advance;

   logic                dec_valid;
   logic [NOW_W-1:0]    dec_now;
   logic [PERIOD_W-1:0] dec_divisor;
   tag_type             dec_tag;

   logic                pha_valid;
   logic [NOW_W-1:0]    pha_quotient;
   logic [PERIOD_W-1:0] pha_phase;
   logic [PERIOD_W-1:0] pha_period;
   tag_type             pha_tag;

   logic                shp_valid;
   logic [SCALED_W-1:0] shp_dividend;
   logic [SCALE_W-1:0]  shp_divisor;
   mark_type            shp_mark;

   logic                lvl_valid;
   logic [QUOT_W-1:0]   lvl_quotient;
   logic [SCALE_W-1:0]  lvl_remainder;
   mark_type            lvl_mark;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= MODE_AUTO;
         cfg_ff.period      <= 16'd4000;
         cfg_ff.start_hour  <= 5'd22;
         cfg_ff.end_hour    <= 5'd6;
         cfg_ff.polarity    <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_MODE:  cfg_ff.mode        <= csr_wdata[3:0];
            CSR_BREATH_PERIOD: cfg_ff.period      <= csr_wdata[PERIOD_W-1:0];
            CSR_WINDOW_START:  cfg_ff.start_hour  <= csr_wdata[HOUR_W-1:0];
            CSR_WINDOW_END:    cfg_ff.end_hour    <= csr_wdata[HOUR_W-1:0];
            CSR_POLARITY:      cfg_ff.polarity    <= csr_wdata[0];
            default:           cfg_ff             <= cfg_ff;
         endcase
      end
   end

   assign req_tready = advance;

   lplg_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .en           (advance),
      .cfg          (cfg_ff),
      .in_valid     (req_tvalid),
      .now_ms       (req_tdata[31:0]),
      .hour_of_day  (req_tdata[36:32]),
      .hour_valid   (req_tdata[37]),
      .touch        (req_tdata[38]),
      .link_up      (req_tdata[39]),
      .out_valid    (dec_valid),
      .out_now      (dec_now),
      .out_divisor  (dec_divisor),
      .out_tag      (dec_tag)
   );

   lplg_divider #(
      .N      (NOW_W),
      .M      (PERIOD_W),
      .Q      (NOW_W),
      .SIDE_W ($bits(tag_type))
   ) u_phase_div (
      .clock         (clock),
      .reset         (reset),
      .en            (advance),
      .in_valid      (dec_valid),
      .in_dividend   (dec_now),
      .in_divisor    (dec_divisor),
      .in_side       (dec_tag),
      .out_valid     (pha_valid),
      .out_quotient  (pha_quotient),
      .out_remainder (pha_phase),
      .out_divisor   (pha_period),
      .out_side      (pha_tag)
   );

   lplg_shape u_shape (
      .clock        (clock),
      .reset        (reset),
      .en           (advance),
      .in_valid     (pha_valid),
      .in_odd       (pha_quotient[0]),
      .in_phase     (pha_phase),
      .in_period    (pha_period),
      .in_tag       (pha_tag),
      .out_valid    (shp_valid),
      .out_dividend (shp_dividend),
      .out_divisor  (shp_divisor),
      .out_mark     (shp_mark)
   );

   lplg_divider #(
      .N      (SCALED_W),
      .M      (SCALE_W),
      .Q      (QUOT_W),
      .SIDE_W ($bits(mark_type))
   ) u_level_div (
      .clock         (clock),
      .reset         (reset),
      .en            (advance),
      .in_valid      (shp_valid),
      .in_dividend   (shp_dividend),
      .in_divisor    (shp_divisor),
      .in_side       (shp_mark),
      .out_valid     (lvl_valid),
      .out_quotient  (lvl_quotient),
      .out_remainder (lvl_remainder),
      .out_divisor   (),
      .out_side      (lvl_mark)
   );

   lplg_output u_output (
      .clock        (clock),
      .reset        (reset),
      .polarity     (cfg_ff.polarity),
      .in_valid     (lvl_valid),
      .in_quotient  (lvl_quotient),
      .in_remainder (lvl_remainder),
      .in_mark      (lvl_mark),
      .advance      (advance),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule
